### src/smof_pkg.sv
// ----------------------------------------------------------------------------
// smof_pkg
// Shared widths, cell operation codes and the controller/datapath bundles
// of the sliding median outlier flag.
// ----------------------------------------------------------------------------
package smof_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned DmedW   = 17;
  localparam int unsigned CountW  = 32;
  localparam int unsigned CfgW    = 7;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_DEL,
    CELL_INS
  } cell_op_e;

  // controller -> datapath, one strobe set per cycle
  typedef struct packed {
    logic     load;     // capture request, read ring and median taps
    logic     emit;     // form the result and load the output register
    logic     advance;  // write ring, step head and fill count
    cell_op_e op;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic filling;
    logic out_free;
  } sts_t;

endpackage

### src/sliding_median_outlier_flag_top.sv
// ----------------------------------------------------------------------------
// sliding_median_outlier_flag_top
// Flags samples that reach the median of the trailing window.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_stall_o    sample_value_i
//   out      output     out_valid_o / out_stall_i  alert_o, doubled_median_o,
//                                                  alert_count_o
//   cfg      input      cfg_we_i                   cfg_wdata_i (window length)
//
// A fill request runs capture and ring read, then insert; a steady request
// runs capture and ring read, delete from the sorted cell chain with the
// result, then insert, as the chain takes one delete and one insert per sample.
// A stalled output holds the delete step until the output register frees.
// Reset is asynchronous, active low, and needs no clearing pass.
// A window length write restarts the fill; the alert count is kept.
// ----------------------------------------------------------------------------
module sliding_median_outlier_flag_top #(
  parameter int unsigned WINDOW_MAX  = 64,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [smof_pkg::SampleW-1:0] sample_value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        alert_o,
  output logic [smof_pkg::DmedW-1:0]  doubled_median_o,
  output logic [smof_pkg::CountW-1:0] alert_count_o,
  input  logic                        cfg_we_i,
  input  logic [smof_pkg::CfgW-1:0]   cfg_wdata_i
);

  smof_pkg::cmd_t cmd;
  smof_pkg::sts_t sts;

  smof_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  smof_datapath #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .sample_value_i   (sample_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .alert_o          (alert_o),
    .doubled_median_o (doubled_median_o),
    .alert_count_o    (alert_count_o)
  );

endmodule

### src/smof_cells.sv
// ----------------------------------------------------------------------------
// smof_cells
// Sorted chain of sample cells. Each cell compares its value with the
// operand and shifts toward or away from its neighbor to delete or insert.
// ----------------------------------------------------------------------------
module smof_cells #(
  parameter int unsigned WINDOW_MAX = 64,
  parameter int unsigned STORE_BITS = 16,
  parameter int unsigned CNT_BITS   = 7
) (
  input  logic                  clk_i,
  input  smof_pkg::cell_op_e    op_i,
  input  logic [STORE_BITS-1:0] op_value_i,
  input  logic [CNT_BITS-1:0]   op_count_i,
  input  logic [CNT_BITS-1:0]   lo_idx_i,
  input  logic [CNT_BITS-1:0]   hi_idx_i,
  output logic [STORE_BITS-1:0] lo_val_o,
  output logic [STORE_BITS-1:0] hi_val_o
);

  logic [STORE_BITS-1:0] cell_q [WINDOW_MAX];
  logic [WINDOW_MAX-1:0] gt;
  logic [WINDOW_MAX-1:0] ge;

  for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
    localparam logic [CNT_BITS-1:0] Pos = CNT_BITS'(g);

    logic                  in_range;
    logic                  at_count;
    logic [STORE_BITS-1:0] lower_v;
    logic [STORE_BITS-1:0] upper_v;
    logic                  lower_gt;

    assign in_range = Pos < op_count_i;
    assign at_count = Pos == op_count_i;
    assign gt[g]    = in_range && (cell_q[g] > op_value_i);
    assign ge[g]    = in_range && (cell_q[g] >= op_value_i);

    if (g == 0) begin : g_first
      assign lower_v  = cell_q[g];
      assign lower_gt = 1'b0;
    end else begin : g_lower
      assign lower_v  = cell_q[g-1];
      assign lower_gt = gt[g-1];
    end

    if (g == WINDOW_MAX - 1) begin : g_last
      assign upper_v = cell_q[g];
    end else begin : g_upper
      assign upper_v = cell_q[g+1];
    end

    always_ff @(posedge clk_i) begin
      unique case (op_i)
        smof_pkg::CELL_DEL: begin
          // close the gap from the first entry not below the old sample
          if (ge[g]) begin
            cell_q[g] <= upper_v;
          end
        end
        smof_pkg::CELL_INS: begin
          if (lower_gt) begin
            cell_q[g] <= lower_v;
          end else if (gt[g] || at_count) begin
            cell_q[g] <= op_value_i;
          end
        end
        default: begin
          cell_q[g] <= cell_q[g];
        end
      endcase
    end
  end

  always_comb begin
    lo_val_o = '0;
    hi_val_o = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      if (CNT_BITS'(i) == lo_idx_i) begin
        lo_val_o = cell_q[i];
      end
      if (CNT_BITS'(i) == hi_idx_i) begin
        hi_val_o = cell_q[i];
      end
    end
  end

endmodule

### src/smof_datapath.sv
// ----------------------------------------------------------------------------
// smof_datapath
// Arrival ring memory, sorted cell chain, window bookkeeping, median compare,
// saturating alert count and the output register.
// ----------------------------------------------------------------------------
module smof_datapath #(
  parameter int unsigned WINDOW_MAX  = 64,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  smof_pkg::cmd_t                   cmd_i,
  output smof_pkg::sts_t                   sts_o,
  input  logic                             cfg_we_i,
  input  logic [smof_pkg::CfgW-1:0]        cfg_wdata_i,
  input  logic [smof_pkg::SampleW-1:0]     sample_value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             alert_o,
  output logic [smof_pkg::DmedW-1:0]       doubled_median_o,
  output logic [smof_pkg::CountW-1:0]      alert_count_o
);

  localparam int unsigned StoreBits =
    (SAMPLE_BITS < smof_pkg::SampleW) ? SAMPLE_BITS : smof_pkg::SampleW;
  localparam int unsigned CntBits  = $clog2(WINDOW_MAX + 1);
  localparam int unsigned HeadBits = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  logic [StoreBits-1:0] ring_mem [WINDOW_MAX];

  logic [CntBits-1:0]   n_q, fill_q, lo_idx_q, hi_idx_q;
  logic [HeadBits-1:0]  head_q;
  logic [StoreBits-1:0] sample_q, old_q, lo_q, hi_q;
  logic [31:0]          total_q;
  logic                 out_valid_q, alert_q;
  logic [StoreBits:0]   dmed_q;

  logic [CntBits-1:0]   n_eff;
  logic                 filling;
  logic [StoreBits-1:0] lo_val, hi_val;
  logic [StoreBits-1:0] op_value;
  logic [CntBits-1:0]   op_count;
  logic [StoreBits:0]   dmed;
  logic                 alert;
  logic [31:0]          total_d;
  logic                 head_wrap;

  // clamp the written length into 1..WINDOW_MAX
  always_comb begin
    priority if (cfg_wdata_i == '0) begin
      n_eff = CntBits'(1);
    end else if (32'(cfg_wdata_i) > WINDOW_MAX) begin
      n_eff = CntBits'(WINDOW_MAX);
    end else begin
      n_eff = CntBits'(cfg_wdata_i);
    end
  end

  assign filling   = fill_q < n_q;
  assign head_wrap = (CntBits'(head_q) + CntBits'(1)) == n_q;

  assign op_value = (cmd_i.op == smof_pkg::CELL_DEL) ? old_q : sample_q;
  always_comb begin
    priority if (cmd_i.op == smof_pkg::CELL_DEL) begin
      op_count = n_q;
    end else if (filling) begin
      op_count = fill_q;
    end else begin
      op_count = n_q - CntBits'(1);
    end
  end

  smof_cells #(
    .WINDOW_MAX (WINDOW_MAX),
    .STORE_BITS (StoreBits),
    .CNT_BITS   (CntBits)
  ) u_cells (
    .clk_i      (clk_i),
    .op_i       (cmd_i.op),
    .op_value_i (op_value),
    .op_count_i (op_count),
    .lo_idx_i   (lo_idx_q),
    .hi_idx_i   (hi_idx_q),
    .lo_val_o   (lo_val),
    .hi_val_o   (hi_val)
  );

  // odd length: both taps sit on the middle entry, so the sum is twice it
  assign dmed    = {1'b0, lo_q} + {1'b0, hi_q};
  assign alert   = {sample_q, 1'b0} >= dmed;
  assign total_d = (alert && !(&total_q)) ? total_q + 32'd1 : total_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.advance) begin
      ring_mem[head_q] <= sample_q;
    end
    if (cmd_i.load) begin
      old_q <= ring_mem[head_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sample_q <= sample_value_i[StoreBits-1:0];
      lo_q     <= lo_val;
      hi_q     <= hi_val;
    end
    if (cmd_i.emit) begin
      alert_q <= alert;
      dmed_q  <= dmed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q         <= CntBits'(1);
      lo_idx_q    <= '0;
      hi_idx_q    <= '0;
      fill_q      <= '0;
      head_q      <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        n_q      <= n_eff;
        lo_idx_q <= (n_eff - CntBits'(1)) >> 1;
        hi_idx_q <= n_eff >> 1;
        fill_q   <= '0;
        head_q   <= '0;
      end else if (cmd_i.advance) begin
        head_q <= head_wrap ? '0 : head_q + HeadBits'(1);
        if (filling) begin
          fill_q <= fill_q + CntBits'(1);
        end
      end
      if (cmd_i.emit) begin
        total_q     <= total_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.filling  = filling;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o      = out_valid_q;
  assign alert_o          = alert_q;
  assign doubled_median_o = smof_pkg::DmedW'(dmed_q);
  assign alert_count_o    = total_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= n_q)
    else $error("fill count above window length");

  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CntBits'(head_q) < n_q)
    else $error("ring head outside window");

  a_emit_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> !filling && sts_o.out_free)
    else $error("result formed from a partial window or over a pending one");

  a_total_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> total_q >= $past(total_q))
    else $error("alert count went backward");

endmodule

### src/smof_ctrl.sv
// ----------------------------------------------------------------------------
// smof_ctrl
// Sequencer for one request: capture, delete the oldest sample and emit the
// result, then insert the new sample. Fill requests skip the delete step.
// ----------------------------------------------------------------------------
module smof_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  smof_pkg::sts_t sts_i,
  output smof_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DEL,
    ST_INS
  } state_e;

  state_e state_q, state_d;
  logic   stall_q, stall_d;

  always_comb begin
    cmd_o   = '{load: 1'b0, emit: 1'b0, advance: 1'b0, op: smof_pkg::CELL_HOLD};
    state_d = state_q;
    stall_d = stall_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && !stall_q) begin
          cmd_o.load = 1'b1;
          stall_d    = 1'b1;
          state_d    = sts_i.filling ? ST_INS : ST_DEL;
        end
      end
      ST_DEL: begin
        // hold until the output register can take the result
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.op   = smof_pkg::CELL_DEL;
          state_d    = ST_INS;
        end
      end
      ST_INS: begin
        cmd_o.op      = smof_pkg::CELL_INS;
        cmd_o.advance = 1'b1;
        stall_d       = 1'b0;
        state_d       = ST_IDLE;
      end
      default: begin
        stall_d = 1'b0;
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      stall_q <= 1'b0;
    end else begin
      state_q <= state_d;
      stall_q <= stall_d;
    end
  end

  assign in_stall_o = stall_q;

  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> in_stall_o && state_q != ST_IDLE)
    else $error("request taken without entering the sequence");

  a_ins_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> cmd_o.op == smof_pkg::CELL_INS)
    else $error("delete not followed by insert");

endmodule
